// ----- sv/mlfq_pkg.sv -----
// Shared types, widths and codes for the multilevel feedback queue scheduler.
// Used by mlfq_level_cell and mlfq_scheduler; depends on nothing.
package mlfq_pkg;

  localparam int NUM_LEVELS_DEF = 4;
  localparam int MAX_TASKS_DEF  = 16;

  localparam int ID_W     = 4;
  localparam int TIME_W   = 32;
  localparam int SVC_W    = 16;
  localparam int LVL_W    = 2;
  localparam int STATUS_W = 2;

  localparam int NUM_SLICES = 4;
  localparam int SLICE_W    = 16;
  localparam int CFG_IDX_W  = 4;

  localparam logic [SLICE_W-1:0] SLICE_RESET [NUM_SLICES] = '{
    SLICE_W'(1), SLICE_W'(2), SLICE_W'(4), SLICE_W'(8)
  };

  localparam logic OP_ARRIVE   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_RUN    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ARRIVE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] arrival_time;
    logic [SVC_W-1:0]  service_time;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     run_task;
    logic [LVL_W-1:0]    run_level;
    logic [TIME_W-1:0]   start_time;
    logic [SVC_W-1:0]    run_length;
    logic [SVC_W-1:0]    remaining;
    logic                finished;
    logic [TIME_W-1:0]   finish_time;
  } rsp_t;

  // Handed from one level cell to the next lower one.
  typedef struct packed {
    logic            claimed;
    logic            dem_valid;
    logic [ID_W-1:0] dem_id;
  } link_t;

  typedef struct packed {
    logic            pop;
    logic            push;
    logic            demote;
    logic [ID_W-1:0] push_id;
  } cell_ctl_t;

  typedef struct packed {
    logic            nonempty;
    logic            full;
    logic            sel;
    logic [ID_W-1:0] head;
  } cell_stat_t;

endpackage

// ----- sv/mlfq_scheduler.sv -----
// Multilevel feedback queue scheduler: a chain of level cells plus a small sequencer.
// An accepted request goes from S_IDLE to S_EXEC, through S_RUN for a slice dispatch, then
// to S_OUT, where the result is loaded into rsp unless the output stalls; a new request is
// taken only back in S_IDLE. A slice run waits on the registered remaining-time read, and
// the sequencer returns to S_IDLE after each result load.
// Reset (rst, synchronous): clears queue pointers, counts, clock; slices go to 1, 2, 4, 8.
// Depends on mlfq_pkg and mlfq_level_cell.
module mlfq_scheduler import mlfq_pkg::*; #(
  parameter int NUM_LEVELS = NUM_LEVELS_DEF,
  parameter int MAX_TASKS  = MAX_TASKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLICE_W-1:0]   cfg_data
);

  localparam int LV_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int TIDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SIX_W  = $clog2(NUM_SLICES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  req_t                req_q;
  rsp_t                res;
  logic [TIME_W-1:0]   now;
  logic [SLICE_W-1:0]  slice [NUM_SLICES];
  logic [SVC_W-1:0]    rmem [MAX_TASKS];
  logic [SVC_W-1:0]    rem_q;
  logic [LV_W-1:0]     run_lv;
  logic [ID_W-1:0]     run_id;

  cell_ctl_t           ctl  [NUM_LEVELS];
  cell_stat_t          stat [NUM_LEVELS];
  link_t               links [NUM_LEVELS + 1];
  logic [NUM_LEVELS:0] full_vec;
  logic [NUM_LEVELS-1:0] sel_vec;

  logic [LV_W-1:0]     pick_lv;
  logic [ID_W-1:0]     pick_id;
  logic                all_empty;
  logic                arr_ok;
  logic [TIME_W-1:0]   arr_time;
  logic [SIX_W-1:0]    slice_idx;
  logic [SLICE_W-1:0]  slc;
  logic [SVC_W-1:0]    run_len;
  logic [SVC_W-1:0]    left;
  logic                done;
  logic                rmem_we;
  logic [TIDX_W-1:0]   rmem_widx;
  logic [SVC_W-1:0]    rmem_wdata;
  logic                rsp_load;

  assign links[0]  = '0;
  assign all_empty = !links[NUM_LEVELS].claimed;

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cell
    mlfq_level_cell #(
      .MAX_TASKS(MAX_TASKS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl[g]),
      .link_in (links[g]),
      .link_out(links[g + 1]),
      .stat    (stat[g])
    );
    assign full_vec[g] = stat[g].full;
    assign sel_vec[g]  = stat[g].sel;
  end
  assign full_vec[NUM_LEVELS] = 1'b1;

  always_comb begin
    pick_lv = '0;
    pick_id = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (stat[l].sel) begin
        pick_lv = LV_W'(l);
        pick_id = stat[l].head;
      end
    end
  end

  assign arr_ok = ({{(TIME_W - ID_W){1'b0}}, req_q.task_id} < TIME_W'(MAX_TASKS)) &&
                  !full_vec[0];
  assign arr_time = (arr_ok && all_empty && (req_q.arrival_time > now)) ?
                    req_q.arrival_time : now;

  assign slice_idx = (TIME_W'(run_lv) >= TIME_W'(NUM_SLICES - 1)) ?
                     SIX_W'(NUM_SLICES - 1) : SIX_W'(run_lv);
  assign slc     = slice[slice_idx];
  assign run_len = (rem_q < slc) ? rem_q : slc;
  assign left    = rem_q - run_len;
  assign done    = (left == '0);

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      ctl[l]         = '0;
      ctl[l].push_id = run_id;
      if (state == S_EXEC && req_q.op == OP_DISPATCH) begin
        ctl[l].pop = stat[l].sel;
      end
      if (state == S_RUN && !done && run_lv == LV_W'(l)) begin
        ctl[l].demote = 1'b1;
        ctl[l].push   = full_vec[l + 1];
      end
    end
    if (state == S_EXEC && req_q.op == OP_ARRIVE) begin
      ctl[0].push    = arr_ok;
      ctl[0].push_id = req_q.task_id;
    end
  end

  always_comb begin
    rmem_we    = 1'b0;
    rmem_widx  = TIDX_W'(run_id);
    rmem_wdata = left;
    if (state == S_EXEC && req_q.op == OP_ARRIVE) begin
      rmem_we    = arr_ok;
      rmem_widx  = TIDX_W'(req_q.task_id);
      rmem_wdata = req_q.service_time;
    end else if (state == S_RUN) begin
      rmem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rmem_we) begin
      rmem[rmem_widx] <= rmem_wdata;
    end
    rem_q <= rmem[TIDX_W'(pick_id)];
  end

  assign rsp_load  = (state == S_OUT) && (!rsp_valid || !rsp_stall);
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (req_q.op == OP_DISPATCH && !all_empty) begin
          state_next = S_RUN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_RUN:  state_next = S_OUT;
      S_OUT:  if (rsp_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      now       <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_SLICES; i++) begin
        slice[i] <= SLICE_RESET[i];
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_SLICES))) begin
        slice[SIX_W'(cfg_index)] <= cfg_data;
      end
      if (state == S_EXEC && req_q.op == OP_ARRIVE) begin
        now <= arr_time;
      end else if (state == S_RUN) begin
        now <= now + TIME_W'(run_len);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == S_EXEC) begin
      run_lv         <= pick_lv;
      run_id         <= pick_id;
      res.run_level  <= '0;
      res.run_length <= '0;
      res.finished   <= 1'b0;
      if (req_q.op == OP_ARRIVE) begin
        res.status      <= ST_ARRIVE;
        res.run_task    <= req_q.task_id;
        res.start_time  <= arr_time;
        res.remaining   <= req_q.service_time;
        res.finish_time <= arr_time;
      end else begin
        res.status      <= ST_EMPTY;
        res.run_task    <= '0;
        res.start_time  <= now;
        res.remaining   <= '0;
        res.finish_time <= now;
      end
    end
    if (state == S_RUN) begin
      res.status      <= ST_RUN;
      res.run_task    <= run_id;
      res.run_level   <= LVL_W'(run_lv);
      res.start_time  <= now;
      res.run_length  <= run_len;
      res.remaining   <= left;
      res.finished    <= done;
      res.finish_time <= now + TIME_W'(run_len);
    end
    if (rsp_load) begin
      rsp <= res;
    end
  end

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(sel_vec))
    else $error("more than one level picked");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_EXEC))
    else $error("accepted beat did not enter execution");

  a_run_after_pick: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ($past(state) == S_EXEC && $past(req_q.op) == OP_DISPATCH))
    else $error("slice run without a dispatch pick");

  a_pick_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && req_q.op == OP_DISPATCH && !all_empty) |-> ($countones(sel_vec) == 1))
    else $error("nonempty queues but no level picked");

endmodule

// ----- sv/mlfq_level_cell.sv -----
// One priority level: a circular FIFO of task ids with head, count and head read.
// Chained to its neighbors for priority pick and demotion; depends on mlfq_pkg.
module mlfq_level_cell import mlfq_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  link_t      link_in,
  output link_t      link_out,
  output cell_stat_t stat
);

  localparam int PTR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [ID_W-1:0]  mem [MAX_TASKS];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [ID_W-1:0]  head_q;
  logic [CNT_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic             full;
  logic             nonempty;
  logic             take_dem;
  logic             push;
  logic [ID_W-1:0]  push_id;

  assign full     = (count == CNT_W'(MAX_TASKS));
  assign nonempty = (count != '0);
  assign take_dem = link_in.dem_valid && !full;
  assign push     = ctl.push || take_dem;
  assign push_id  = take_dem ? link_in.dem_id : ctl.push_id;

  assign tail_sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
  assign tail     = (tail_sum >= (CNT_W + 1)'(MAX_TASKS)) ?
                    PTR_W'(tail_sum - (CNT_W + 1)'(MAX_TASKS)) : PTR_W'(tail_sum);

  always_comb begin
    head_next  = head;
    count_next = count;
    if (ctl.pop) begin
      head_next = (head == PTR_W'(MAX_TASKS - 1)) ? '0 : head + PTR_W'(1);
    end
    if (push && !ctl.pop) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_id;
    end
    head_q <= mem[head];
  end

  assign link_out.claimed   = link_in.claimed || nonempty;
  assign link_out.dem_valid = ctl.demote;
  assign link_out.dem_id    = ctl.push_id;

  assign stat.nonempty = nonempty;
  assign stat.full     = full;
  assign stat.sel      = nonempty && !link_in.claimed;
  assign stat.head     = head_q;

endmodule
